// ===== design/mbe_pkg.sv =====
`default_nettype none

package mbe_pkg;

    // Fixed-point and image constants
    localparam int FRAC_BITS = 28;
    localparam int IMAGE_DIM = 8192;

    localparam int IDX_W   = 13;
    localparam int COUNT_W = 16;
    localparam int STEP_W  = 28;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 64;
    localparam int CIDX_W  = 3;

    // |z|^2 >= 4 in Q(2*FRAC_BITS)
    localparam logic [PROD_W-1:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_LIMIT     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ORIGIN_RE = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ORIGIN_IM = 3'd2;
    localparam logic [CIDX_W-1:0] REG_STEP_RE   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_STEP_IM   = 3'd4;

    // Reset values
    localparam logic [COUNT_W-1:0]       RST_LIMIT     = 16'd1000;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_RE = -32'sd563714458;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_IM = -32'sd348966093;
    localparam logic [STEP_W-1:0]        RST_STEP_RE   = 28'd101581;
    localparam logic [STEP_W-1:0]        RST_STEP_IM   = 28'd85197;

    typedef struct packed {
        logic [IDX_W-1:0] column_index;
        logic [IDX_W-1:0] row_index;
    } mbe_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic               inside_set;
    } mbe_out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       iteration_limit;
        logic signed [DATA_W-1:0] origin_re;
        logic signed [DATA_W-1:0] origin_im;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
    } mbe_cfg_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // Indexes past the image edge pin to the last pixel
    function automatic logic [IDX_W-1:0] sat_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (32'(idx) >= IMAGE_DIM)
            r = IDX_W'(IMAGE_DIM - 1);
        else
            r = idx;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mbe_cfg.sv =====
`default_nettype none

module mbe_cfg
    import mbe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    output mbe_cfg_t               cfg
);

    mbe_cfg_t cfg_reg;
    mbe_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIMIT:     cfg_next.iteration_limit = cfg_data[COUNT_W-1:0];
                REG_ORIGIN_RE: cfg_next.origin_re       = cfg_data;
                REG_ORIGIN_IM: cfg_next.origin_im       = cfg_data;
                REG_STEP_RE:   cfg_next.step_re         = cfg_data[STEP_W-1:0];
                REG_STEP_IM:   cfg_next.step_im         = cfg_data[STEP_W-1:0];
                default:       cfg_next = cfg_reg;   // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.iteration_limit <= RST_LIMIT;
            cfg_reg.origin_re       <= RST_ORIGIN_RE;
            cfg_reg.origin_im       <= RST_ORIGIN_IM;
            cfg_reg.step_re         <= RST_STEP_RE;
            cfg_reg.step_im         <= RST_STEP_IM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mbe_mul.sv =====
`default_nettype none

module mbe_mul
    import mbe_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [DATA_W-1:0] a,
    input  wire logic signed [DATA_W-1:0] b,
    output logic signed [PROD_W-1:0]      p
);

    logic signed [PROD_W-1:0] p_reg;

    // signed 32x32, full 64-bit product registered
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== design/mbe_core.sv =====
`default_nettype none

module mbe_core
    import mbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mbe_cfg_t cfg,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire mbe_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output mbe_out_t      out_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CRE   = 4'd1;  // issue col*step_re
    localparam logic [3:0] S_CIM   = 4'd2;  // c_re, issue row*step_im
    localparam logic [3:0] S_CINIT = 4'd3;  // c_im, z = 0
    localparam logic [3:0] S_XX    = 4'd4;  // limit check, issue x*x
    localparam logic [3:0] S_YY    = 4'd5;  // latch xx, issue y*y
    localparam logic [3:0] S_XY    = 4'd6;  // escape test, xx-yy, issue x*y
    localparam logic [3:0] S_UPD   = 4'd7;  // z update or escape
    localparam logic [3:0] S_DONE  = 4'd8;  // hand result to output reg

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]         col_reg, row_reg;
    logic signed [DATA_W-1:0] cre_reg, cim_reg;
    logic signed [DATA_W-1:0] x_reg, y_reg;
    logic signed [PROD_W-1:0] xx_reg, diff_reg;
    logic                     esc_reg, inside_reg;
    logic [COUNT_W-1:0]       count_reg;
    mbe_out_t                 out_data_reg;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                     accept;
    logic                     load_out;
    logic [PROD_W-1:0]        mag;
    logic signed [PROD_W-1:0] nx_sum, ny_sum;

    mbe_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign mag    = xx_reg + prod;
    assign nx_sum = (diff_reg >>> FRAC_BITS) + PROD_W'(cre_reg);
    assign ny_sum = (prod >>> (FRAC_BITS - 1)) + PROD_W'(cim_reg);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_CRE:
            begin
                mul_a = DATA_W'({1'b0, col_reg});
                mul_b = DATA_W'({1'b0, cfg.step_re});
            end
            S_CIM:
            begin
                mul_a = DATA_W'({1'b0, row_reg});
                mul_b = DATA_W'({1'b0, cfg.step_im});
            end
            S_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            S_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            S_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CRE;
            S_CRE:   state_next = S_CIM;
            S_CIM:   state_next = S_CINIT;
            S_CINIT: state_next = S_XX;
            S_XX:    state_next = (count_reg >= cfg.iteration_limit) ? S_DONE : S_YY;
            S_YY:    state_next = S_XY;
            S_XY:    state_next = S_UPD;
            S_UPD:   state_next = esc_reg ? S_DONE : S_XX;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= sat_index(in_data.column_index);
            row_reg <= sat_index(in_data.row_index);
        end
        case (state_reg)
            S_CIM:
            begin
                cre_reg <= sat32(PROD_W'(cfg.origin_re) + prod);
            end
            S_CINIT:
            begin
                cim_reg   <= sat32(PROD_W'(cfg.origin_im) + prod);
                x_reg     <= '0;
                y_reg     <= '0;
                count_reg <= '0;
            end
            S_XX:
            begin
                inside_reg <= 1'b1;
            end
            S_YY:
            begin
                xx_reg <= prod;
            end
            S_XY:
            begin
                esc_reg  <= (mag >= ESC_BOUND);
                diff_reg <= xx_reg - prod;
            end
            S_UPD:
            begin
                if (esc_reg)
                begin
                    inside_reg <= 1'b0;
                end
                else
                begin
                    x_reg     <= sat32(nx_sum);
                    y_reg     <= sat32(ny_sum);
                    count_reg <= count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_data_reg.iteration_count <= count_reg;
            out_data_reg.inside_set      <= inside_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time pixel engine.
// Input channel (in_valid / in_stall / in_data): one word per pixel holding the
// column and row index. A word is taken on a clock edge with in_valid high and
// in_stall low. in_stall is high from acceptance until the result is handed to
// the output register, so one pixel is in flight at a time.
// Output channel (out_valid / out_stall / out_data): one word per pixel with the
// iteration count and the inside-set flag, held in an output register. The next
// pixel may be accepted while a finished word still waits there; a stalled word
// stays put, and a pixel that finishes meanwhile waits until it drains.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; write only while no pixel is in flight. Unknown indexes drop.
// Sequence: one signed 32x32 multiplier is shared by all products. Setup forms
// c_re and c_im; each iteration runs a limit check, x*x, y*y, x*y with the
// escape test, and the update, and a hand-off to the output register ends the
// pixel. The default iteration limit is 1000. A new pixel can be taken in the
// cycle after the hand-off.
// Reset (rst_n, async low) restores the default view and limit and clears the
// sequencer and the output valid flag.
`default_nettype none

module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mbe_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output mbe_out_t               out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data
);

    mbe_cfg_t cfg;

    // register file: limit, origin and step of the view
    mbe_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer, datapath and output register around the shared multiplier
    mbe_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

// Escape-time engine bench.
// Stimulus goes out on the pixel channel; a shadow copy of the view registers
// tracks every config write, and each accepted pixel word is run through an
// in-bench escape-time model. The resulting words queue up in order and the
// output checker pops one per accepted output word.
module tb_top;
    import mbe_pkg::*;

    // Cycles without any accepted word before the run is declared hung. The
    // slowest pixel is the one held at the 16-bit limit.
    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam int VIEWS_PER_PHASE  = 5;
    localparam int PIXELS_PER_VIEW  = 25;

    // Q4.28 range and escape radius (|z|^2 >= 4 at 2*FRAC_BITS fraction bits)
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint unsigned ESCAPE_MAG = 64'd4 << (2 * FRAC_BITS);

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    mbe_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    mbe_out_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIDX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    // Shadow of the view registers, as the engine should hold them
    logic [COUNT_W-1:0]       view_limit     = RST_LIMIT;
    logic signed [DATA_W-1:0] view_origin_re = RST_ORIGIN_RE;
    logic signed [DATA_W-1:0] view_origin_im = RST_ORIGIN_IM;
    logic [STEP_W-1:0]        view_step_re   = RST_STEP_RE;
    logic [STEP_W-1:0]        view_step_im   = RST_STEP_IM;

    mbe_out_t predicted_escapes[$];
    int       error_count   = 0;
    int       idle_cycles   = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;

    mandelbrot_escape_time uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Escape-time model
    // ---------------------------------------------------------------

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    function automatic mbe_out_t escape_time(input mbe_in_t px);
        longint          col;
        longint          row;
        longint          c_re;
        longint          c_im;
        longint          x;
        longint          y;
        longint          xx;
        longint          yy;
        longint          nx;
        longint          ny;
        longint unsigned mag;
        int unsigned     n;
        mbe_out_t        r;
        col = longint'(px.column_index);
        row = longint'(px.row_index);
        // pixels past the image edge pin to the last one
        if (col >= IMAGE_DIM)
            col = IMAGE_DIM - 1;
        if (row >= IMAGE_DIM)
            row = IMAGE_DIM - 1;
        c_re = clamp_word(longint'(view_origin_re) + col * longint'(view_step_re));
        c_im = clamp_word(longint'(view_origin_im) + row * longint'(view_step_im));
        x = 0;
        y = 0;
        n = 0;
        // limit reached ends the loop before the escape test of the last z
        while (n < view_limit)
        begin
            xx  = x * x;
            yy  = y * y;
            mag = longint'(xx) + longint'(yy);
            if (mag >= ESCAPE_MAG)
                break;
            // >>> on a signed value rounds toward minus infinity
            nx = clamp_word(((xx - yy) >>> FRAC_BITS) + c_re);
            ny = clamp_word(((x * y) >>> (FRAC_BITS - 1)) + c_im);
            x  = nx;
            y  = ny;
            n++;
        end
        r.iteration_count = n[COUNT_W-1:0];
        r.inside_set      = (n == view_limit);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Monitors: config shadow, pixel predictions, watchdog
    // ---------------------------------------------------------------

    // Sampled at the rising edge: the engine's outputs still hold their
    // pre-edge values here, inputs were set up at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LIMIT:     view_limit     = cfg_data[COUNT_W-1:0];
                    REG_ORIGIN_RE: view_origin_re = cfg_data;
                    REG_ORIGIN_IM: view_origin_im = cfg_data;
                    REG_STEP_RE:   view_step_re   = cfg_data[STEP_W-1:0];
                    REG_STEP_IM:   view_step_im   = cfg_data[STEP_W-1:0];
                    default:       ;  // unmapped index: dropped
                endcase
            end
            if (in_valid && !in_stall)
                predicted_escapes = {predicted_escapes, escape_time(in_data)};
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall)
                || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result checker: each accepted output word against the oldest prediction
    always @(posedge clk)
    begin
        mbe_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_escapes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected word: count %0d inside %0b",
                             out_data.iteration_count, out_data.inside_set);
            end
            else
            begin
                want = predicted_escapes.pop_front();
                if (out_data.iteration_count !== want.iteration_count
                    || out_data.inside_set !== want.inside_set)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: count exp %0d got %0d, inside exp %0b got %0b",
                                 want.iteration_count, out_data.iteration_count,
                                 want.inside_set, out_data.inside_set);
                end
            end
        end
    end

    // Output backpressure, redrawn every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // ---------------------------------------------------------------
    // Drivers (all called at a falling edge, return at a falling edge)
    // ---------------------------------------------------------------

    // One pixel word; valid stays up across back-to-back words
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid             <= 1'b1;
        in_data.column_index <= col;
        in_data.row_index    <= row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait for every predicted word to come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_escapes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Full register set; the upper bits of the limit write carry junk
    task automatic load_view(input logic [COUNT_W-1:0] lim,
                             input logic [DATA_W-1:0] o_re, input logic [DATA_W-1:0] o_im,
                             input logic [DATA_W-1:0] s_re, input logic [DATA_W-1:0] s_im);
        wait_idle();
        write_reg(REG_LIMIT, {16'($urandom), lim});
        write_reg(REG_ORIGIN_RE, o_re);
        write_reg(REG_ORIGIN_IM, o_im);
        write_reg(REG_STEP_RE, s_re);
        write_reg(REG_STEP_IM, s_im);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Default view straight out of reset: corners escape fast, the two
    // interior points (near 0 and near -1) run to the 1000 limit.
    task automatic test_reset_view();
        send_pixel(IDX_W'(0), IDX_W'(0));
        send_pixel(IDX_W'(IMAGE_DIM - 1), IDX_W'(IMAGE_DIM - 1));
        send_pixel(IDX_W'(IMAGE_DIM - 1), IDX_W'(0));
        send_pixel(IDX_W'(0), IDX_W'(IMAGE_DIM - 1));
        send_pixel(IDX_W'(5550), IDX_W'(4096));
        send_pixel(IDX_W'(2800), IDX_W'(4096));
    endtask

    // Zero limit: no iteration at all, always flagged inside
    task automatic test_zero_limit();
        load_view(COUNT_W'(0), RST_ORIGIN_RE, RST_ORIGIN_IM, RST_STEP_RE, RST_STEP_IM);
        send_pixel(IDX_W'(5550), IDX_W'(4096));
        send_pixel(IDX_W'(0), IDX_W'(0));
    endtask

    // c = 2: |z1|^2 lands exactly on 4. With limit 1 the loop ends on the
    // limit first (inside), with limit 2 it escapes after one iteration.
    task automatic test_last_iteration_escape();
        load_view(COUNT_W'(1), 32'(2 << FRAC_BITS), '0, '0, '0);
        send_pixel(IDX_W'(17), IDX_W'(99));
        load_view(COUNT_W'(2), 32'(2 << FRAC_BITS), '0, '0, '0);
        send_pixel(IDX_W'(17), IDX_W'(99));
        load_view(COUNT_W'(3), -32'sd536870912, '0, '0, '0);
        send_pixel(IDX_W'(0), IDX_W'(0));
    endtask

    // Origins at both ends of the word range; large indexes push c past the top end
    task automatic test_saturated_view();
        load_view(COUNT_W'(16), 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff);
        send_pixel(IDX_W'(IMAGE_DIM - 1), IDX_W'(0));
        send_pixel(IDX_W'(0), IDX_W'(IMAGE_DIM - 1));
        send_pixel(IDX_W'(IMAGE_DIM - 1), IDX_W'(IMAGE_DIM - 1));
        send_pixel(IDX_W'(0), IDX_W'(0));
    endtask

    // Writes to unmapped indexes must not disturb the view
    task automatic test_unknown_register();
        load_view(COUNT_W'(200), -32'sd402653184, -32'sd268435456, 32'd65536, 32'd65536);
        for (int i = int'(REG_STEP_IM) + 1; i < (1 << CIDX_W); i++)
            write_reg(CIDX_W'(i), $urandom);
        send_pixel(IDX_W'(4096), IDX_W'(4096));
        send_pixel(IDX_W'(1234), IDX_W'(6000));
    endtask

    // Largest limit on c = 0: one pixel that runs the full 65535 iterations
    task automatic test_limit_extreme();
        load_view(16'hffff, '0, '0, '0, '0);
        send_pixel(IDX_W'(IMAGE_DIM - 1), IDX_W'(0));
    endtask

    // Random views under each idling profile. Most views frame the set so
    // pixels split between escaping and bounded orbits; some are raw noise.
    task automatic test_random_views();
        logic [COUNT_W-1:0] lim;
        logic [DATA_W-1:0]  o_re;
        logic [DATA_W-1:0]  o_im;
        logic [DATA_W-1:0]  s_re;
        logic [DATA_W-1:0]  s_im;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 53; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            for (int v = 0; v < VIEWS_PER_PHASE; v++)
            begin
                if ($urandom_range(4) == 0)
                    lim = COUNT_W'($urandom_range(65, 400));
                else
                    lim = COUNT_W'($urandom_range(1, 64));
                if ($urandom_range(11) == 0)
                    lim = '0;
                if ($urandom_range(3) == 0)
                begin
                    o_re = $urandom;
                    o_im = $urandom;
                    s_re = $urandom;
                    s_im = $urandom;
                end
                else
                begin
                    // real -2.5..0.5, imag -1.5..1.5, span up to 4 across the image
                    o_re = 32'(int'($urandom_range(0, 3 << FRAC_BITS)) - (5 << (FRAC_BITS - 1)));
                    o_im = 32'(int'($urandom_range(0, 3 << FRAC_BITS)) - (3 << (FRAC_BITS - 1)));
                    s_re = $urandom_range(0, 1 << 17);
                    s_im = $urandom_range(0, 1 << 17);
                end
                load_view(lim, o_re, o_im, s_re, s_im);
                for (int k = 0; k < PIXELS_PER_VIEW; k++)
                    send_pixel(IDX_W'($urandom_range(0, IMAGE_DIM - 1)),
                               IDX_W'($urandom_range(0, IMAGE_DIM - 1)));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_view();
        test_zero_limit();
        test_last_iteration_escape();
        test_saturated_view();
        test_unknown_register();
        test_limit_extreme();
        test_random_views();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && predicted_escapes.size() == 0)
            $display("TEST PASSED");
        else
        begin
            if (predicted_escapes.size() != 0)
                $display("%0d predicted words never arrived", predicted_escapes.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
